### rtl/ook_pkg.sv
package ook_pkg;

  // Width of the tick counter for one half pulse
  localparam int DUR_BITS = 16;
  localparam int FRAME_W  = 32;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Register map, byte address 4 * index
  typedef enum logic [2:0] {
    REG_DEVICE_CODE  = 3'd0,
    REG_REPEAT_COUNT = 3'd1,
    REG_SYNC_COUNT   = 3'd2,
    REG_SYNC_WIDTH   = 3'd3,
    REG_LONG_WIDTH   = 3'd4,
    REG_SHORT_WIDTH  = 3'd5
  } reg_idx_e;

  // Register reset values
  localparam logic [7:0]  RST_DEVICE_CODE  = 8'd0;
  localparam logic [7:0]  RST_REPEAT_COUNT = 8'd15;
  localparam logic [3:0]  RST_SYNC_COUNT   = 4'd5;
  localparam logic [15:0] RST_SYNC_WIDTH   = 16'd1000;
  localparam logic [15:0] RST_LONG_WIDTH   = 16'd490;
  localparam logic [15:0] RST_SHORT_WIDTH  = 16'd160;

  typedef struct packed {
    logic [7:0]  device_code;
    logic [7:0]  repeat_count;
    logic [3:0]  sync_count;
    logic [15:0] sync_width;
    logic [15:0] long_width;
    logic [15:0] short_width;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic start_taken;
  } res_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic                sending;
    logic                high_phase;
    logic [DUR_BITS-1:0] ticks_left;
  } seq_status_t;

endpackage

### rtl/ook_in_if.sv
interface ook_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [11:0] temp_tenths;

  modport source (output valid, output kind, output temp_tenths, input ready);
  modport sink   (input valid, input kind, input temp_tenths, output ready);
endinterface

### rtl/ook_out_if.sv
interface ook_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic start_taken;

  modport source (output valid, output line_level, output busy_res, output start_taken,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input start_taken,
                  output ready);
endinterface

### rtl/ook_cfg_regs.sv
module ook_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ook_pkg::ADDR_W-1:0]   paddr,
  input  logic [ook_pkg::DATA_W-1:0]   pwdata,
  output logic [ook_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ook_pkg::cfg_t                cfg
);
  import ook_pkg::*;

  cfg_t     cfg_r;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_code  <= RST_DEVICE_CODE;
      cfg_r.repeat_count <= RST_REPEAT_COUNT;
      cfg_r.sync_count   <= RST_SYNC_COUNT;
      cfg_r.sync_width   <= RST_SYNC_WIDTH;
      cfg_r.long_width   <= RST_LONG_WIDTH;
      cfg_r.short_width  <= RST_SHORT_WIDTH;
    end else if (wr_en) begin
      case (idx)
        REG_DEVICE_CODE:  cfg_r.device_code  <= pwdata[7:0];
        REG_REPEAT_COUNT: cfg_r.repeat_count <= pwdata[7:0];
        REG_SYNC_COUNT:   cfg_r.sync_count   <= pwdata[3:0];
        REG_SYNC_WIDTH:   cfg_r.sync_width   <= pwdata[15:0];
        REG_LONG_WIDTH:   cfg_r.long_width   <= pwdata[15:0];
        REG_SHORT_WIDTH:  cfg_r.short_width  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_DEVICE_CODE:  prdata = {24'd0, cfg_r.device_code};
      REG_REPEAT_COUNT: prdata = {24'd0, cfg_r.repeat_count};
      REG_SYNC_COUNT:   prdata = {28'd0, cfg_r.sync_count};
      REG_SYNC_WIDTH:   prdata = {16'd0, cfg_r.sync_width};
      REG_LONG_WIDTH:   prdata = {16'd0, cfg_r.long_width};
      REG_SHORT_WIDTH:  prdata = {16'd0, cfg_r.short_width};
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/ook_frame_build.sv
module ook_frame_build (
  input  logic signed [11:0]             temp_tenths,
  input  logic [7:0]                     device_code,
  output logic [ook_pkg::FRAME_W-1:0]    frame
);
  import ook_pkg::*;

  localparam logic signed [11:0] TEMP_MIN    = -12'sd550;
  localparam logic signed [11:0] TEMP_MAX    = 12'sd1250;
  localparam logic [11:0]        TEMP_OFFSET = 12'd1280;
  localparam logic [7:0]         CSUM_BIAS   = 8'h88;

  function automatic logic [7:0] swap_nibbles(input logic [7:0] b);
    return {b[3:0], b[7:4]};
  endfunction

  logic signed [11:0] t_clip;
  logic [11:0]        scaled;
  logic [7:0]         hi_byte;
  logic [7:0]         lo_byte;
  logic [7:0]         sum;

  // Clip, offset, then checksum over nibble-swapped bytes
  always_comb begin
    if (temp_tenths < TEMP_MIN)      t_clip = TEMP_MIN;
    else if (temp_tenths > TEMP_MAX) t_clip = TEMP_MAX;
    else                             t_clip = temp_tenths;
    scaled  = $unsigned(t_clip) + TEMP_OFFSET;
    hi_byte = {4'd0, scaled[11:8]};
    lo_byte = scaled[7:0];
    sum     = CSUM_BIAS + swap_nibbles(lo_byte) + swap_nibbles(hi_byte)
              + swap_nibbles(device_code);
    frame   = {device_code, hi_byte, lo_byte, swap_nibbles(sum)};
  end

endmodule

### rtl/ook_pulse_seq.sv
module ook_pulse_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        kind,
  input  logic [ook_pkg::FRAME_W-1:0] frame_in,
  input  ook_pkg::cfg_t               cfg,
  output ook_pkg::res_t               res,
  output ook_pkg::seq_status_t        status
);
  import ook_pkg::*;

  localparam logic [31:0] DUR_CAP = {32{1'b1}} >> (32 - DUR_BITS);

  // Width of 0 counts as 1, anything above the counter range saturates
  function automatic logic [DUR_BITS-1:0] clamp_width(input logic [15:0] w);
    logic [31:0] v;
    v = {16'd0, w};
    if (v == 32'd0)   v = 32'd1;
    if (v > DUR_CAP)  v = DUR_CAP;
    return v[DUR_BITS-1:0];
  endfunction

  logic [FRAME_W-1:0]  frame_r,   frame_nxt;
  logic [7:0]          rep_r,     rep_nxt;
  logic [5:0]          pidx_r,    pidx_nxt;
  logic                high_r,    high_nxt;
  logic [DUR_BITS-1:0] ticks_r,   ticks_nxt;
  logic                sending_r, sending_nxt;

  logic        load;
  logic [4:0]  bit_idx;
  logic        cur_bit;
  logic [15:0] width;
  logic        copy_end;

  assign copy_end = ({1'b0, pidx_r} + 7'd1) >= ({3'd0, cfg.sync_count} + 7'd32);

  always_comb begin
    frame_nxt   = frame_r;
    rep_nxt     = rep_r;
    pidx_nxt    = pidx_r;
    high_nxt    = high_r;
    ticks_nxt   = ticks_r;
    sending_nxt = sending_r;
    load        = 1'b0;
    res         = '0;

    if (take) begin
      if (kind == KIND_START) begin
        // Start only from idle; a start while busy leaves time alone
        if (!sending_r) begin
          frame_nxt       = frame_in;
          rep_nxt         = (cfg.repeat_count == 8'd0) ? 8'd1 : cfg.repeat_count;
          pidx_nxt        = 6'd0;
          high_nxt        = 1'b0;
          sending_nxt     = 1'b1;
          load            = 1'b1;
          res.start_taken = 1'b1;
        end
        res.line_level = sending_nxt & high_nxt;
      end else if (sending_r) begin
        res.line_level = high_r;
        if (ticks_r > DUR_BITS'(1)) begin
          ticks_nxt = ticks_r - DUR_BITS'(1);
        end else begin
          ticks_nxt = '0;
          if (!high_r) begin
            high_nxt = 1'b1;
            load     = 1'b1;
          end else begin
            high_nxt = 1'b0;
            if (copy_end) begin
              pidx_nxt = 6'd0;
              rep_nxt  = rep_r - 8'd1;
              if (rep_nxt == 8'd0) sending_nxt = 1'b0;
              else                 load        = 1'b1;
            end else begin
              pidx_nxt = pidx_r + 6'd1;
              load     = 1'b1;
            end
          end
        end
      end
      res.busy_res = sending_nxt;
    end

    // Duration of the half pulse that begins now
    bit_idx = pidx_nxt[4:0] - {1'b0, cfg.sync_count};
    cur_bit = frame_nxt[~bit_idx];
    if (pidx_nxt < {2'd0, cfg.sync_count}) width = cfg.sync_width;
    else if (cur_bit)                      width = high_nxt ? cfg.short_width : cfg.long_width;
    else                                   width = high_nxt ? cfg.long_width : cfg.short_width;
    if (load) ticks_nxt = clamp_width(width);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      rep_r     <= '0;
      pidx_r    <= '0;
      high_r    <= 1'b0;
      ticks_r   <= '0;
      sending_r <= 1'b0;
    end else begin
      frame_r   <= frame_nxt;
      rep_r     <= rep_nxt;
      pidx_r    <= pidx_nxt;
      high_r    <= high_nxt;
      ticks_r   <= ticks_nxt;
      sending_r <= sending_nxt;
    end
  end

  assign status.sending    = sending_r;
  assign status.high_phase = high_r;
  assign status.ticks_left = ticks_r;

endmodule

### rtl/ook_sensor_frame_transmitter.sv
// On-off-keyed sensor frame transmitter. A start transfer (kind 1) latches a
// temperature in tenths of a degree and sends the 4-byte frame (device code,
// scaled high byte, scaled low byte, checksum) repeat_count times (once if 0), each
// copy led by sync_count sync pulses; every tick transfer (kind 0) advances the line
// by one tick and returns the level. Every input transfer gives exactly one result,
// valid in the output register from the next clock cycle. The block takes one item
// per clock cycle: the pulse sequencer's next state is combinational, and a new item
// is let in at the same edge as the waiting result leaves, so only a stalled
// consumer slows it. The user must write registers through the APB port only while
// idle; the block does not enforce this. The first transfer may follow reset directly.
module ook_sensor_frame_transmitter (
  input  logic                        clk,
  input  logic                        rst_n,
  ook_in_if.sink                      in_ch,
  ook_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ook_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ook_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ook_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import ook_pkg::*;

  cfg_t               cfg;
  logic [FRAME_W-1:0] frame;
  res_t               res;
  seq_status_t        status;
  logic               take;
  logic               out_valid_r;
  res_t               out_res_r;

  ook_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ook_frame_build u_frame (
    .temp_tenths (in_ch.temp_tenths),
    .device_code (cfg.device_code),
    .frame       (frame)
  );

  ook_pulse_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .kind     (in_ch.kind),
    .frame_in (frame),
    .cfg      (cfg),
    .res      (res),
    .status   (status)
  );

  // Input taken whenever the output register is free or being emptied
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign take        = in_ch.valid & in_ch.ready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_res_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.line_level  = out_res_r.line_level;
  assign out_ch.busy_res    = out_res_r.busy_res;
  assign out_ch.start_taken = out_res_r.start_taken;

  // Every accepted item leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("accepted item left no result");

  // An accepted start always reports a message in progress
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.start_taken |-> out_res_r.busy_res)
    else $error("start taken without busy");

  // While sending, the half-pulse counter never sits at zero
  a_ticks_live: assert property (@(posedge clk) disable iff (!rst_n)
    status.sending |-> status.ticks_left != '0)
    else $error("tick counter empty while sending");

  // Idle line stays low
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    !status.sending |-> !status.high_phase)
    else $error("high phase while idle");

endmodule

### verif/tb.sv
module tb;
  import ook_pkg::*;

  // Temperature handling and frame constants
  localparam int         TEMP_MIN    = -550;
  localparam int         TEMP_MAX    = 1250;
  localparam int         TEMP_OFFSET = 1280;
  localparam logic [7:0] CSUM_SEED   = 8'h88;

  // Run control
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 3000;
  localparam int DRAIN_TICKS    = 16;
  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic               kind;
    logic signed [11:0] temp;
  } tx_item_t;

  logic clk = 1'b0;
  logic rst_n;

  ook_in_if  in_ch ();
  ook_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  ook_sensor_frame_transmitter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Items waiting to go in, and line results still owed by the block
  tx_item_t tx_items[$];
  res_t     line_results[$];

  int src_idle  = 0;
  int snk_idle  = 0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  bit in_xfer   = 1'b0;
  int n_fail    = 0;
  int stall_cnt = 0;

  // Transmitter mirror: register copy plus sequencer state
  cfg_t        tx_cfg;
  logic [31:0] tx_frame;
  logic [7:0]  tx_reps;
  logic [5:0]  tx_pidx;
  logic        tx_high;
  logic [15:0] tx_ticks;
  logic        tx_sending;

  function automatic tx_item_t mk_item(logic kind, logic signed [11:0] temp);
    tx_item_t it;
    it.kind = kind;
    it.temp = temp;
    return it;
  endfunction

  function automatic logic [7:0] nib_swap(logic [7:0] b);
    return {b[3:0], b[7:4]};
  endfunction

  // Mostly legal temperatures, now and then any 12-bit code
  function automatic logic signed [11:0] rand_temp();
    if ($urandom_range(9) < 7)
      return 12'(int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
    return 12'($urandom);
  endfunction

  // Length of the half pulse that starts now; zero widths count as one tick
  function automatic logic [15:0] half_len();
    logic [15:0] w;
    int          b;
    if (tx_pidx < tx_cfg.sync_count) begin
      w = tx_cfg.sync_width;
    end else begin
      b = (int'(tx_pidx) - int'(tx_cfg.sync_count)) & (FRAME_W - 1);
      if (tx_frame[FRAME_W-1-b])
        w = tx_high ? tx_cfg.short_width : tx_cfg.long_width;
      else
        w = tx_high ? tx_cfg.long_width : tx_cfg.short_width;
    end
    return (w == 16'd0) ? 16'd1 : w;
  endfunction

  // One tick of the pulse sequencer
  task automatic tick_advance();
    if (tx_ticks > 16'd1) begin
      tx_ticks--;
    end else begin
      tx_ticks = '0;
      if (!tx_high) begin
        tx_high  = 1'b1;
        tx_ticks = half_len();
      end else begin
        tx_high = 1'b0;
        if (int'(tx_pidx) + 1 >= int'(tx_cfg.sync_count) + FRAME_W) begin
          tx_pidx = '0;
          tx_reps = tx_reps - 8'd1;
          if (tx_reps == 8'd0)
            tx_sending = 1'b0;
          else
            tx_ticks = half_len();
        end else begin
          tx_pidx  = tx_pidx + 6'd1;
          tx_ticks = half_len();
        end
      end
    end
  endtask

  // Result of one item, updating the mirror
  task automatic line_predict(input logic kind, input logic signed [11:0] temp, output res_t r);
    int          t;
    logic [15:0] scaled;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  sum;
    r = '0;
    if (kind == KIND_START) begin
      if (!tx_sending) begin
        t = temp;
        if (t < TEMP_MIN) t = TEMP_MIN;
        if (t > TEMP_MAX) t = TEMP_MAX;
        scaled = 16'(t + TEMP_OFFSET);
        lo  = scaled[7:0];
        hi  = scaled[15:8];
        sum = CSUM_SEED + nib_swap(lo) + nib_swap(hi) + nib_swap(tx_cfg.device_code);
        tx_frame   = {tx_cfg.device_code, hi, lo, nib_swap(sum)};
        tx_reps    = (tx_cfg.repeat_count == 8'd0) ? 8'd1 : tx_cfg.repeat_count;
        tx_pidx    = '0;
        tx_high    = 1'b0;
        tx_sending = 1'b1;
        tx_ticks   = half_len();
        r.start_taken = 1'b1;
      end
      r.line_level = tx_sending ? tx_high : 1'b0;
    end else if (tx_sending) begin
      r.line_level = tx_high;
      tick_advance();
    end
    r.busy_res = tx_sending;
  endtask

  // Input side: note each transfer and predict its result
  always @(posedge clk) begin : in_accept
    res_t r;
    in_xfer = rst_n && in_ch.valid && in_ch.ready;
    if (in_xfer) begin
      line_predict(in_ch.kind, in_ch.temp_tenths, r);
      line_results.push_back(r);
    end
  end

  // Driver: present the next item once the current one has gone
  always @(negedge clk) begin : in_drive
    tx_item_t it;
    if (rst_n && (!in_ch.valid || in_xfer)) begin
      if (tx_items.size() != 0 && $urandom_range(99) >= src_idle) begin
        it = tx_items.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= it.kind;
        in_ch.temp_tenths <= it.temp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off on request
  always @(negedge clk) begin : out_pace
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : out_check
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (line_results.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%0t: unexpected result level %0b busy %0b taken %0b", $time,
                   out_ch.line_level, out_ch.busy_res, out_ch.start_taken);
      end else begin
        want = line_results.pop_front();
        if (want.line_level !== out_ch.line_level || want.busy_res !== out_ch.busy_res ||
            want.start_taken !== out_ch.start_taken) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: mismatch, expected level %0b busy %0b taken %0b, got %0b %0b %0b",
                     $time, want.line_level, want.busy_res, want.start_taken,
                     out_ch.line_level, out_ch.busy_res, out_ch.start_taken);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
      stall_cnt = 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cnt++;
    end
  end

  // Write every register over the APB port, block idle
  task automatic set_config(input cfg_t c);
    logic [31:0] val;
    for (int i = REG_DEVICE_CODE; i <= REG_SHORT_WIDTH; i++) begin
      case (reg_idx_e'(i))
        REG_DEVICE_CODE:  val = 32'(c.device_code);
        REG_REPEAT_COUNT: val = 32'(c.repeat_count);
        REG_SYNC_COUNT:   val = 32'(c.sync_count);
        REG_SYNC_WIDTH:   val = 32'(c.sync_width);
        REG_LONG_WIDTH:   val = 32'(c.long_width);
        default:          val = 32'(c.short_width);
      endcase
      @(negedge clk);
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= ADDR_W'(4 * i);
      cfg_pwdata  <= val;
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tx_cfg = c;
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(24) == 0)
        tx_items.push_back(mk_item(KIND_START, rand_temp()));
      else
        tx_items.push_back(mk_item(KIND_TICK, 12'($urandom)));
    end
  endtask

  // Until every item has gone in and every result has come back
  task automatic wait_idle();
    while (tx_items.size() != 0 || in_ch.valid || line_results.size() != 0)
      @(posedge clk);
  endtask

  // Tick on until the current message has finished
  task automatic drain_message();
    wait_idle();
    while (tx_sending) begin
      repeat (DRAIN_TICKS) tx_items.push_back(mk_item(KIND_TICK, 12'($urandom)));
      wait_idle();
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    int   lead_temps[RAND_PHASES];

    lead_temps = '{2047, -550, 1250, -551, 1251, 0, -1, 1249};

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_TICK;
    in_ch.temp_tenths = '0;
    out_ch.ready      = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;

    tx_cfg = '{RST_DEVICE_CODE, RST_REPEAT_COUNT, RST_SYNC_COUNT,
               RST_SYNC_WIDTH, RST_LONG_WIDTH, RST_SHORT_WIDTH};
    tx_frame   = '0;
    tx_reps    = '0;
    tx_pidx    = '0;
    tx_high    = 1'b0;
    tx_ticks   = '0;
    tx_sending = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle ticks, clipping, start while busy, repeat of zero
    src_idle = 8;
    snk_idle = 45;
    c = '{8'hFF, 8'd0, 4'd0, 16'd0, 16'd1, 16'd2};
    set_config(c);
    tx_items.push_back(mk_item(KIND_TICK, 12'h000));
    tx_items.push_back(mk_item(KIND_TICK, 12'hFFF));
    tx_items.push_back(mk_item(KIND_TICK, 12'h7FF));
    tx_items.push_back(mk_item(KIND_START, 12'h800));
    tx_items.push_back(mk_item(KIND_START, 12'h7FF));
    repeat (3) tx_items.push_back(mk_item(KIND_TICK, 12'h555));
    tx_items.push_back(mk_item(KIND_START, 12'(TEMP_MIN)));
    repeat (14) tx_items.push_back(mk_item(KIND_TICK, 12'hAAA));
    drain_message();

    // Random phases with small widths, each led by a boundary temperature
    for (int k = 0; k < RAND_PHASES; k++) begin
      if (k < 3) begin
        src_idle = 8;
        snk_idle = 45;
      end else if (k < 6) begin
        src_idle = 45;
        snk_idle = 8;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      c.device_code  = (k == 0) ? 8'h00 : 8'($urandom);
      c.repeat_count = (k == 1) ? 8'd1 : 8'($urandom_range(3));
      c.sync_count   = (k == 2) ? 4'd15 : 4'($urandom);
      c.sync_width   = 16'($urandom_range(2));
      c.long_width   = 16'($urandom_range(2));
      c.short_width  = 16'($urandom_range(2));
      set_config(c);
      if (k == 1) hold_req = 1'b1;
      tx_items.push_back(mk_item(KIND_START, 12'(lead_temps[k])));
      push_random(ITEMS_PER_PHASE);
      drain_message();
    end

    // A longer message with several copies
    c = '{8'h3C, 8'd4, 4'd1, 16'd1, 16'd1, 16'd1};
    set_config(c);
    tx_items.push_back(mk_item(KIND_START, 12'sd321));
    drain_message();

    // Widest settings: the message outlasts the run
    c = '{8'h96, 8'd255, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    set_config(c);
    tx_items.push_back(mk_item(KIND_START, -12'sd300));
    push_random(150);
    wait_idle();

    repeat (8) @(posedge clk);
    if (n_fail == 0 && line_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
